// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; define ASSERT_OFF to drop
// every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant violated");

// cons holds in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/wea_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed exponential average package
// Widths, register indexes and reset values of the windowed average unit.
// ----------------------------------------------------------------------------
package wea_pkg;

  // sample and accumulator widths
  localparam int SAMPLE_BITS    = 16;
  localparam int SUM_BITS       = 40;
  localparam int FRAC_BITS      = 16;
  localparam int DEF_MAX_WINDOW = 64;

  // configuration register widths
  localparam int WLEN_W     = 7;
  localparam int WEIGHT_W   = 17;
  localparam int INIT_SUM_W = 38;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 38;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OLDEST_WEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SUM_RECIP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SUM      = 3'd5;

  // register reset values
  localparam logic [WLEN_W-1:0]            RST_WINDOW_LENGTH    = 7'd10;
  localparam logic [WEIGHT_W-1:0]          RST_DECAY_FACTOR     = 17'd65536;
  localparam logic [WEIGHT_W-1:0]          RST_OLDEST_WEIGHT    = 17'd65536;
  localparam logic [WEIGHT_W-1:0]          RST_WEIGHT_SUM_RECIP = 17'd6554;
  localparam logic signed [SAMPLE_BITS-1:0] RST_PAD_VALUE       = '0;
  localparam logic signed [INIT_SUM_W-1:0]  RST_INITIAL_SUM     = '0;

  // shared multiplier: signed chunk times zero-extended weight
  localparam int LO_W    = 24;
  localparam int MUL_A_W = LO_W + 1;
  localparam int MUL_B_W = WEIGHT_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // difference and accumulator widths
  localparam int D_W    = SUM_BITS + 1;
  localparam int ACC_W  = 60;
  localparam int SNEW_W = SUM_BITS + 6;
  localparam int Y_W    = ACC_W - 2 * FRAC_BITS;

endpackage

// ===== rtl/windowed_exponential_average_unit.sv =====
// ----------------------------------------------------------------------------
// Windowed exponential average unit: takes one sample at a time and accepts no
// new one until its result is registered; each item makes five passes through
// the one shared 25x18 multiplier plus subtract, accumulate and saturate steps.
// Synchronous rst loads register defaults and empties the window; no clear pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_exponential_average_unit
  import wea_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] sample
  input  logic [0:0]            s_tuser,   // [0] restart
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [15:0] filtered
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

  localparam logic signed [ACC_W-1:0] ROUND_D = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ROUND_Y = ACC_W'(1) <<< (2 * FRAC_BITS - 1);
  localparam logic signed [SNEW_W-1:0] SUM_MAX =
    SNEW_W'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
  localparam logic signed [SNEW_W-1:0] SUM_MIN = -SUM_MAX - SNEW_W'(1);
  localparam logic signed [Y_W-1:0] SMP_MAX = Y_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Y_W-1:0] SMP_MIN = -SMP_MAX - Y_W'(1);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_OLD  = 11'b000_0000_0010,
    ST_DSUB = 11'b000_0000_0100,
    ST_DLO  = 11'b000_0000_1000,
    ST_DHI  = 11'b000_0001_0000,
    ST_DACC = 11'b000_0010_0000,
    ST_SNEW = 11'b000_0100_0000,
    ST_SLO  = 11'b000_1000_0000,
    ST_SHI  = 11'b001_0000_0000,
    ST_YACC = 11'b010_0000_0000,
    ST_YOUT = 11'b100_0000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [WLEN_W-1:0]             window_length;
  logic [WEIGHT_W-1:0]           decay_factor;
  logic [WEIGHT_W-1:0]           oldest_weight;
  logic [WEIGHT_W-1:0]           weight_sum_recip;
  logic signed [SAMPLE_BITS-1:0] pad_value;
  logic signed [INIT_SUM_W-1:0]  initial_sum;

  // filter state
  logic [SAMPLE_BITS-1:0]        mem [MAX_WINDOW];
  logic [ADDR_W-1:0]             wp;
  logic [CNT_W-1:0]              fill;
  logic signed [SUM_BITS-1:0]    sum;

  // per-item working registers
  logic signed [SAMPLE_BITS-1:0] x;
  logic                          use_init_q;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [D_W-1:0]         d;
  logic signed [MUL_P_W-1:0]     prod;
  logic signed [ACC_W-1:0]       acc;

  logic                          in_fire;
  logic                          restart;
  logic [LEN_W-1:0]              wl_ext;
  logic [CNT_W-1:0]              n_eff;
  logic [CNT_W:0]                rd_sum;
  logic [ADDR_W-1:0]             rd_addr;
  logic [ADDR_W-1:0]             wp_next;
  logic                          use_init;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [MUL_P_W-1:0]     mul_p;
  logic signed [SNEW_W-1:0]      snew_sum;
  logic signed [SUM_BITS-1:0]    snew_sat;
  logic signed [Y_W-1:0]         y_full;
  logic [SAMPLE_BITS-1:0]        y_sat;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign restart  = s_tuser[0];

  // effective window length, clamped to 1..MAX_WINDOW
  assign wl_ext = LEN_W'(window_length);
  always_comb begin
    if (wl_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (wl_ext > LEN_W'(MAX_WINDOW)) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = wl_ext[CNT_W-1:0];
    end
  end

  // slot of the sample leaving the window, and pointer advance
  assign rd_sum  = (CNT_W+1)'(wp) + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(n_eff);
  assign rd_addr = (rd_sum >= (CNT_W+1)'(MAX_WINDOW)) ?
                   ADDR_W'(rd_sum - (CNT_W+1)'(MAX_WINDOW)) : ADDR_W'(rd_sum);
  assign wp_next = (wp == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;

  // unfilled slots stand for pad_value
  assign use_init = restart || (fill < n_eff);
  assign old_val  = use_init_q ? pad_value : rd_data;

  // delay line: raw sample written, leaving sample read (old data on a collision)
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[wp] <= s_tdata[SAMPLE_BITS-1:0];
      rd_data <= $signed(mem[rd_addr]);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = MUL_B_W'(decay_factor);
    case (state)
      ST_OLD: begin
        mul_a = MUL_A_W'(old_val);
        mul_b = MUL_B_W'(oldest_weight);
      end
      ST_DLO: begin
        mul_a = $signed(MUL_A_W'(d[LO_W-1:0]));
      end
      ST_DHI: begin
        mul_a = MUL_A_W'($signed(d[D_W-1:LO_W]));
      end
      ST_SLO: begin
        mul_a = $signed(MUL_A_W'(sum[LO_W-1:0]));
        mul_b = MUL_B_W'(weight_sum_recip);
      end
      ST_SHI: begin
        mul_a = MUL_A_W'($signed(sum[SUM_BITS-1:LO_W]));
        mul_b = MUL_B_W'(weight_sum_recip);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // product register
  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  // new running sum: rounded shift, add sample, saturate to sum width
  assign snew_sum = SNEW_W'($signed(acc[ACC_W-1:FRAC_BITS])) + (SNEW_W'(x) <<< FRAC_BITS);
  always_comb begin
    if (snew_sum > SUM_MAX) begin
      snew_sat = SUM_MAX[SUM_BITS-1:0];
    end else if (snew_sum < SUM_MIN) begin
      snew_sat = SUM_MIN[SUM_BITS-1:0];
    end else begin
      snew_sat = snew_sum[SUM_BITS-1:0];
    end
  end

  // output value: rounded shift by 32, saturate to sample width
  assign y_full = $signed(acc[ACC_W-1:2*FRAC_BITS]);
  always_comb begin
    if (y_full > SMP_MAX) begin
      y_sat = SMP_MAX[SAMPLE_BITS-1:0];
    end else if (y_full < SMP_MIN) begin
      y_sat = SMP_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_full[SAMPLE_BITS-1:0];
    end
  end

  // sequencer, configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      m_tvalid         <= 1'b0;
      wp               <= '0;
      fill             <= '0;
      sum              <= '0;
      window_length    <= RST_WINDOW_LENGTH;
      decay_factor     <= RST_DECAY_FACTOR;
      oldest_weight    <= RST_OLDEST_WEIGHT;
      weight_sum_recip <= RST_WEIGHT_SUM_RECIP;
      pad_value        <= RST_PAD_VALUE;
      initial_sum      <= RST_INITIAL_SUM;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WINDOW_LENGTH:    window_length    <= cfg_wdata[WLEN_W-1:0];
          REG_DECAY_FACTOR:     decay_factor     <= cfg_wdata[WEIGHT_W-1:0];
          REG_OLDEST_WEIGHT:    oldest_weight    <= cfg_wdata[WEIGHT_W-1:0];
          REG_WEIGHT_SUM_RECIP: weight_sum_recip <= cfg_wdata[WEIGHT_W-1:0];
          REG_PAD_VALUE:        pad_value        <= $signed(cfg_wdata[SAMPLE_BITS-1:0]);
          REG_INITIAL_SUM:      initial_sum      <= $signed(cfg_wdata[INIT_SUM_W-1:0]);
          default: ;
        endcase
      end

      // result request taken; the last step reloads it itself
      if (m_tvalid && m_tready && (state != ST_YOUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            x          <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            use_init_q <= use_init;
            wp         <= wp_next;
            if (restart) begin
              sum  <= SUM_BITS'(initial_sum);
              fill <= CNT_W'(1);
            end else if (fill < CNT_W'(MAX_WINDOW)) begin
              fill <= fill + 1'b1;
            end
            state <= ST_OLD;
          end
        end
        ST_OLD: begin
          state <= ST_DSUB;
        end
        ST_DSUB: begin
          d     <= D_W'(sum) - $signed(prod[D_W-1:0]);
          state <= ST_DLO;
        end
        ST_DLO: begin
          state <= ST_DHI;
        end
        ST_DHI: begin
          acc   <= ACC_W'(prod);
          state <= ST_DACC;
        end
        ST_DACC: begin
          acc   <= acc + (ACC_W'(prod) <<< LO_W) + ROUND_D;
          state <= ST_SNEW;
        end
        ST_SNEW: begin
          sum   <= snew_sat;
          state <= ST_SLO;
        end
        ST_SLO: begin
          state <= ST_SHI;
        end
        ST_SHI: begin
          acc   <= ACC_W'(prod);
          state <= ST_YACC;
        end
        ST_YACC: begin
          acc   <= acc + (ACC_W'(prod) <<< LO_W) + ROUND_Y;
          state <= ST_YOUT;
        end
        ST_YOUT: begin
          // wait for the output register to free up
          if (!m_tvalid || m_tready) begin
            m_tdata  <= y_sat;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `ASSERT_NEXT(a_accept_starts_seq, clk, rst, s_tvalid && s_tready, state == ST_OLD)
  `ASSERT_IMPLY(a_result_from_last_step, clk, rst, $rose(m_tvalid), $past(state) == ST_YOUT)
  `ASSERT_ALWAYS(a_fill_in_range, clk, rst, fill <= CNT_W'(MAX_WINDOW))

endmodule
